// ----- sv/tvc_pkg.sv -----
// Shared types and constants for the tetrahedron volume and circumdiameter block.
`default_nettype none
package tvc_pkg;

  localparam int IN_BITS     = 16;
  localparam int VOL_BITS    = 52;
  localparam int DIAM_BITS   = 24;
  localparam int VOL_FRAC    = 24;
  localparam int DIAM_FRAC   = 8;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [IN_BITS-1:0] a_x;
    logic signed [IN_BITS-1:0] a_y;
    logic signed [IN_BITS-1:0] a_z;
    logic signed [IN_BITS-1:0] b_x;
    logic signed [IN_BITS-1:0] b_y;
    logic signed [IN_BITS-1:0] b_z;
    logic signed [IN_BITS-1:0] c_x;
    logic signed [IN_BITS-1:0] c_y;
    logic signed [IN_BITS-1:0] c_z;
    logic signed [IN_BITS-1:0] d_x;
    logic signed [IN_BITS-1:0] d_y;
    logic signed [IN_BITS-1:0] d_z;
  } in_t;

  typedef struct packed {
    logic [VOL_BITS-1:0]  volume_out;
    logic [DIAM_BITS-1:0] diameter_out;
    logic                 degenerate;
  } out_t;

  // floor(n / 3) for n below 768, by reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [19:0] t;
    t = 20'(n) * 20'd683;
    return t[18:11];
  endfunction

endpackage
`default_nettype wire

// ----- sv/tvc_front.sv -----
// Front pipeline: edge vectors, determinant, volume, opposite-edge products and P.
`default_nettype none
module tvc_front import tvc_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8,
  localparam int ADB = 3*(COORD_BITS+1)+3,
  localparam int PB  = 8*COORD_BITS+11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_t                 in_data,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output logic [PB-1:0]            p_o,
  output logic [ADB-1:0]           ad_o,
  output logic [VOL_BITS-1:0]      vol_o,
  output logic                     degen_o
);

  localparam int CB   = COORD_BITS;
  localparam int DB   = CB+1;
  localparam int CPB  = 2*DB+1;
  localparam int D2B  = 2*CB+2;
  localparam int LB   = 2*D2B;
  localparam int HB   = LB/2;
  localparam int PPB  = 2*LB;
  localparam int EW   = (CB > IN_BITS) ? CB : IN_BITS;
  localparam int VSH  = VOL_FRAC-3*FRAC_BITS;
  localparam int LSH  = (VSH > 0) ? VSH : 0;
  localparam int RSH  = (VSH < 0) ? -VSH : 0;
  localparam int XVB  = ADB+LSH;
  localparam int ND   = (XVB+6)/8;
  localparam int YPB  = 8*ND;
  localparam int NF   = 9+ND;
  localparam int QEW  = (YPB > VOL_BITS) ? YPB : VOL_BITS;

  function automatic logic signed [CB-1:0] crd(input logic [IN_BITS-1:0] f);
    logic [EW-1:0] z;
    z = EW'(f);
    return z[CB-1:0];
  endfunction

  logic [NF-1:0] fv_r;
  logic          en;

  in_t                     in_r;
  logic signed [CB-1:0]    vtx [4][3];
  logic signed [DB-1:0]    ed_nxt [6][3];
  logic signed [DB-1:0]    ed_r [6][3];
  logic signed [2*DB-1:0]  mp_nxt [6];
  logic signed [2*DB-1:0]  mp_r [6];
  logic signed [2*DB-1:0]  sqw [6][3];
  logic [2*CB-1:0]         sq_r [6][3];
  logic signed [DB-1:0]    e2_r [3];
  logic signed [CPB-1:0]   c_nxt [3];
  logic signed [CPB-1:0]   c_r [3];
  logic [D2B-1:0]          d2_nxt [6];
  logic [D2B-1:0]          d2_r [6];
  logic signed [DB-1:0]    e3_r [3];
  logic signed [DB+CPB-1:0] dt_nxt [3];
  logic signed [DB+CPB-1:0] dt_r [3];
  logic [LB-1:0]           l4_r [3];
  logic signed [ADB-1:0]   det;
  logic [ADB-1:0]          ad5_r;
  logic [LB-1:0]           l5_r [3];
  logic [LB-1:0]           pr_r [6][4];
  logic [ADB-1:0]          ad6_r;
  logic [YPB-1:0]          y6_r;
  logic [PPB-1:0]          prod_nxt [6];
  logic [PPB-1:0]          prod_r [6];
  logic [ADB-1:0]          ad7_r;
  logic [YPB-1:0]          y7_r;
  logic [PB:0]             spos;
  logic [PB:0]             sneg;
  logic [PB:0]             sdif;
  logic [PB-1:0]           cp_r  [ND+1];
  logic [ADB-1:0]          cad_r [ND+1];
  logic [YPB-1:0]          w_r   [ND+1];
  logic [1:0]              r3_r  [ND+1];
  logic [QEW-1:0]          qe;

  assign en         = !(fv_r[NF-1] && !push_ready);
  assign in_ready   = en;
  assign push_valid = fv_r[NF-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[NF-2:0], in_valid};
    end
  end

  always_comb begin
    vtx[0][0] = crd(in_r.a_x);
    vtx[0][1] = crd(in_r.a_y);
    vtx[0][2] = crd(in_r.a_z);
    vtx[1][0] = crd(in_r.b_x);
    vtx[1][1] = crd(in_r.b_y);
    vtx[1][2] = crd(in_r.b_z);
    vtx[2][0] = crd(in_r.c_x);
    vtx[2][1] = crd(in_r.c_y);
    vtx[2][2] = crd(in_r.c_z);
    vtx[3][0] = crd(in_r.d_x);
    vtx[3][1] = crd(in_r.d_y);
    vtx[3][2] = crd(in_r.d_z);
    // edges ab, ac, ad, bc, bd, cd
    for (int k = 0; k < 3; k++) begin
      ed_nxt[0][k] = DB'(vtx[1][k]) - DB'(vtx[0][k]);
      ed_nxt[1][k] = DB'(vtx[2][k]) - DB'(vtx[0][k]);
      ed_nxt[2][k] = DB'(vtx[3][k]) - DB'(vtx[0][k]);
      ed_nxt[3][k] = DB'(vtx[2][k]) - DB'(vtx[1][k]);
      ed_nxt[4][k] = DB'(vtx[3][k]) - DB'(vtx[1][k]);
      ed_nxt[5][k] = DB'(vtx[3][k]) - DB'(vtx[2][k]);
    end
  end

  always_comb begin
    mp_nxt[0] = ed_r[1][1] * ed_r[2][2];
    mp_nxt[1] = ed_r[1][2] * ed_r[2][1];
    mp_nxt[2] = ed_r[1][2] * ed_r[2][0];
    mp_nxt[3] = ed_r[1][0] * ed_r[2][2];
    mp_nxt[4] = ed_r[1][0] * ed_r[2][1];
    mp_nxt[5] = ed_r[1][1] * ed_r[2][0];
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 3; k++) begin
        sqw[i][k] = ed_r[i][k] * ed_r[i][k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_nxt[k] = CPB'(mp_r[2*k]) - CPB'(mp_r[2*k+1]);
    end
    for (int i = 0; i < 6; i++) begin
      d2_nxt[i] = D2B'(sq_r[i][0]) + D2B'(sq_r[i][1]) + D2B'(sq_r[i][2]);
    end
    for (int k = 0; k < 3; k++) begin
      dt_nxt[k] = e3_r[k] * c_r[k];
    end
    det = ADB'(dt_r[0]) + ADB'(dt_r[1]) + ADB'(dt_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
      ed_r <= ed_nxt;
      mp_r <= mp_nxt;
      for (int i = 0; i < 6; i++) begin
        for (int k = 0; k < 3; k++) begin
          sq_r[i][k] <= sqw[i][k][2*CB-1:0];
        end
      end
      e2_r  <= ed_r[0];
      c_r   <= c_nxt;
      d2_r  <= d2_nxt;
      e3_r  <= e2_r;
      dt_r  <= dt_nxt;
      l4_r[0] <= d2_r[3] * d2_r[2];
      l4_r[1] <= d2_r[1] * d2_r[4];
      l4_r[2] <= d2_r[0] * d2_r[5];
      ad5_r <= det[ADB-1] ? ADB'(-det) : ADB'(det);
      l5_r  <= l4_r;
      ad6_r <= ad5_r;
      y6_r  <= YPB'(((XVB'(ad5_r) << LSH) >> RSH) >> 1);
      prod_r <= prod_nxt;
      ad7_r <= ad6_r;
      y7_r  <= y6_r;
    end
  end

  // split 2-way partial products of the six L products
  for (genvar n = 0; n < 6; n++) begin : g_part
    localparam int A = (n < 3) ? n : n-3;
    localparam int B = (n < 3) ? (n+1)%3 : n-3;
    always_ff @(posedge clk) begin
      if (en) begin
        pr_r[n][0] <= l5_r[A][HB-1:0]  * l5_r[B][HB-1:0];
        pr_r[n][1] <= l5_r[A][HB-1:0]  * l5_r[B][LB-1:HB];
        pr_r[n][2] <= l5_r[A][LB-1:HB] * l5_r[B][HB-1:0];
        pr_r[n][3] <= l5_r[A][LB-1:HB] * l5_r[B][LB-1:HB];
      end
    end
    assign prod_nxt[n] = PPB'(pr_r[n][0]) + (PPB'(pr_r[n][1]) << HB)
                       + (PPB'(pr_r[n][2]) << HB) + (PPB'(pr_r[n][3]) << LB);
  end

  always_comb begin
    spos = ((PB+1)'(prod_r[0]) + (PB+1)'(prod_r[1]) + (PB+1)'(prod_r[2])) << 1;
    sneg = (PB+1)'(prod_r[3]) + (PB+1)'(prod_r[4]) + (PB+1)'(prod_r[5]);
    sdif = spos - sneg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_r[0]  <= sdif[PB] ? '0 : sdif[PB-1:0];
      cad_r[0] <= ad7_r;
      w_r[0]   <= y7_r;
      r3_r[0]  <= 2'd0;
    end
  end

  // divide by three, one byte per stage
  for (genvar j = 1; j <= ND; j++) begin : g_div3
    logic [9:0] cur;
    logic [7:0] q;
    logic [9:0] rm;
    assign cur = {r3_r[j-1], w_r[j-1][YPB-1 -: 8]};
    assign q   = div3(cur);
    assign rm  = cur - 10'(q) * 10'd3;
    always_ff @(posedge clk) begin
      if (en) begin
        cp_r[j]  <= cp_r[j-1];
        cad_r[j] <= cad_r[j-1];
        w_r[j]   <= {w_r[j-1][YPB-9:0], q};
        r3_r[j]  <= rm[1:0];
      end
    end
  end

  assign qe      = QEW'(w_r[ND]);
  assign degen_o = (w_r[ND] == '0);
  assign vol_o   = ((qe >> VOL_BITS) != '0) ? '1 : qe[VOL_BITS-1:0];
  assign p_o     = cp_r[ND];
  assign ad_o    = cad_r[ND];

endmodule
`default_nettype wire

// ----- sv/tvc_queue.sv -----
// Short transaction queue between the front and back pipelines.
`default_nettype none
module tvc_queue import tvc_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH+1);

  logic [WIDTH-1:0] mem_r [QUEUE_DEPTH];
  logic [AW-1:0]    wp_r, rp_r, wp_nxt, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = (wp_r == AW'(QUEUE_DEPTH-1)) ? '0 : wp_r + 1'b1;
    rp_nxt  = (rp_r == AW'(QUEUE_DEPTH-1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_nxt;
      if (pop) rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count step");
`endif

endmodule
`default_nettype wire

// ----- sv/tvc_back.sv -----
// Back pipeline: square root of P, saturating divide into the diameter, result register.
`default_nettype none
module tvc_back import tvc_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8,
  localparam int ADB = 3*(COORD_BITS+1)+3,
  localparam int PB  = 8*COORD_BITS+11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire logic [PB-1:0]       q_p,
  input  wire logic [ADB-1:0]      q_ad,
  input  wire logic [VOL_BITS-1:0] q_vol,
  input  wire logic                q_degen,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_t                     out_data
);

  localparam int XB  = PB+2*DIAM_FRAC;
  localparam int RB  = (XB+1)/2;
  localparam int TW  = 2*RB+2;
  localparam int MSH = FRAC_BITS+1;
  localparam int QB0 = ADB+MSH+DIAM_BITS;
  localparam int QB  = ((RB > QB0) ? RB : QB0)+1;
  localparam int NB  = RB+DIAM_BITS+2;

  logic [NB-1:0]        bv_r;
  logic                 en;
  logic [TW-1:0]        srem_r  [RB+1];
  logic [RB-1:0]        sroot_r [RB+1];
  logic [ADB-1:0]       cad_r   [NB];
  logic [VOL_BITS-1:0]  cvol_r  [NB];
  logic                 cdg_r   [NB];
  logic [QB-1:0]        drem_r  [DIAM_BITS+1];
  logic [DIAM_BITS-1:0] q_r     [DIAM_BITS+1];
  logic                 sat_r   [DIAM_BITS+1];

  assign en        = !(bv_r[NB-1] && !out_ready);
  assign q_ready   = en;
  assign out_valid = bv_r[NB-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (en) begin
      bv_r <= {bv_r[NB-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srem_r[0]  <= TW'({q_p, {(2*DIAM_FRAC){1'b0}}});
      sroot_r[0] <= '0;
      cad_r[0]   <= q_ad;
      cvol_r[0]  <= q_vol;
      cdg_r[0]   <= q_degen;
    end
  end

  for (genvar k = 1; k < NB; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en) begin
        cad_r[k]  <= cad_r[k-1];
        cvol_r[k] <= cvol_r[k-1];
        cdg_r[k]  <= cdg_r[k-1];
      end
    end
  end

  // one root bit per stage
  for (genvar k = 1; k <= RB; k++) begin : g_sqrt
    localparam int I = RB-k;
    logic [TW-1:0] trial;
    logic          ge;
    assign trial = (TW'(sroot_r[k-1]) << (I+1)) | (TW'(1) << (2*I));
    assign ge    = (srem_r[k-1] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[k]  <= ge ? srem_r[k-1] - trial : srem_r[k-1];
        sroot_r[k] <= ge ? (sroot_r[k-1] | (RB'(1) << I)) : sroot_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem_r[0] <= QB'(sroot_r[RB]);
      q_r[0]    <= '0;
      sat_r[0]  <= cdg_r[RB] ||
                   (QB'(sroot_r[RB]) >= (QB'(cad_r[RB]) << (MSH+DIAM_BITS)));
    end
  end

  // one quotient bit per stage
  for (genvar j = 1; j <= DIAM_BITS; j++) begin : g_div
    localparam int I = DIAM_BITS-j;
    logic [QB-1:0] t;
    logic          ge;
    assign t  = QB'(cad_r[RB+j]) << (MSH+I);
    assign ge = (drem_r[j-1] >= t);
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[j] <= ge ? drem_r[j-1] - t : drem_r[j-1];
        q_r[j]    <= ge ? (q_r[j-1] | (DIAM_BITS'(1) << I)) : q_r[j-1];
        sat_r[j]  <= sat_r[j-1];
      end
    end
  end

  always_comb begin
    out_data.volume_out   = cvol_r[NB-1];
    out_data.diameter_out = sat_r[DIAM_BITS] ? '1 : q_r[DIAM_BITS];
    out_data.degenerate   = cdg_r[NB-1];
  end

endmodule
`default_nettype wire

// ----- sv/tetrahedron_volume_circumdiameter.sv -----
// Top level: tetrahedron volume and circumsphere diameter, one transaction per cycle.
// Throughput: one transaction per cycle when out_ready is held high.
// Pipeline: (9 + ND) front stages, the queue and (RB + 26) back stages, where
//   ND = ceil((bits of |det| scaled) / 8) and RB = half the width of P << 16.
// The back square root, one bit per stage, sets the depth.
// Reset: synchronous active-low rst_n clears all valid flags and queue pointers.
`default_nettype none
module tetrahedron_volume_circumdiameter import tvc_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int ADB = 3*(COORD_BITS+1)+3;
  localparam int PB  = 8*COORD_BITS+11;
  localparam int QW  = PB+ADB+VOL_BITS+1;

  logic                f_valid, f_ready, b_valid, b_ready;
  logic [PB-1:0]       f_p;
  logic [ADB-1:0]      f_ad;
  logic [VOL_BITS-1:0] f_vol;
  logic                f_degen;
  logic [QW-1:0]       b_data;

  tvc_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .p_o        (f_p),
    .ad_o       (f_ad),
    .vol_o      (f_vol),
    .degen_o    (f_degen)
  );

  tvc_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_p, f_ad, f_vol, f_degen}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  tvc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_p       (b_data[QW-1 -: PB]),
    .q_ad      (b_data[ADB+VOL_BITS : VOL_BITS+1]),
    .q_vol     (b_data[VOL_BITS:1]),
    .q_degen   (b_data[0]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_degen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.diameter_out == '1)
    else $error("degenerate result without saturated diameter");
  a_degen_vol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.degenerate == (out_data.volume_out == '0))
    else $error("degenerate flag disagrees with volume");
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> f_valid && !f_ready)
    else $error("input stalled without a full queue");
`endif

endmodule
`default_nettype wire

// ----- bench/tetrahedron_volume_circumdiameter_tb.sv -----
// Self-checking testbench for the tetrahedron volume and circumdiameter block.
`timescale 1ns / 1ps
`default_nettype none
module tetrahedron_volume_circumdiameter_tb;
  import tvc_pkg::*;

  localparam int N_RANDOM   = 1730;
  localparam int DRAIN_AT   = 900;
  localparam int CALM_TAIL  = 200;
  localparam int TAIL_WAIT  = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  in_t  tetra_q[$];
  out_t shape_q[$];
  int   n_total = 0;
  int   n_issued = 0;
  int   n_checked = 0;
  int   n_degen = 0;
  int   n_sat = 0;
  int   n_bad = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  bit   stim_done = 1'b0;

  always #4 clk = ~clk;

  tetrahedron_volume_circumdiameter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  function automatic out_t tetra_shape(in_t t);
    logic signed [255:0] crd[12];
    logic signed [255:0] e[3][3];
    logic signed [255:0] d2[4][4];
    logic signed [255:0] cx, cy, cz, det, l1, l2, l3, pp;
    logic [255:0] ad, vol, x, r, c, m, dia;
    out_t o;
    for (int i = 0; i < 12; i++) crd[i] = $signed(t[191-16*i -: 16]);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) e[i][k] = crd[(i+1)*3+k] - crd[k];
    cx = e[1][1]*e[2][2] - e[1][2]*e[2][1];
    cy = e[1][2]*e[2][0] - e[1][0]*e[2][2];
    cz = e[1][0]*e[2][1] - e[1][1]*e[2][0];
    det = e[0][0]*cx + e[0][1]*cy + e[0][2]*cz;
    ad = (det < 0) ? -det : det;
    vol = ad / 6;
    o.degenerate = (vol == 0);
    o.volume_out = (vol > {VOL_BITS{1'b1}}) ? {VOL_BITS{1'b1}} : vol[VOL_BITS-1:0];
    if (o.degenerate) begin
      o.diameter_out = {DIAM_BITS{1'b1}};
      return o;
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        d2[i][j] = 0;
        for (int k = 0; k < 3; k++)
          d2[i][j] += (crd[i*3+k] - crd[j*3+k]) * (crd[i*3+k] - crd[j*3+k]);
      end
    l1 = d2[1][2] * d2[0][3];
    l2 = d2[0][2] * d2[1][3];
    l3 = d2[0][1] * d2[2][3];
    pp = 2 * (l1*l2 + l2*l3 + l3*l1) - (l1*l1 + l2*l2 + l3*l3);
    if (pp < 0) pp = 0;
    x = pp << (2 * DIAM_FRAC);
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      c = r | (256'd1 << b);
      if (c * c <= x) r = c;
    end
    m = ad << 9;
    if (r >= (m << DIAM_BITS)) dia = {DIAM_BITS{1'b1}};
    else dia = r / m;
    o.diameter_out = dia[DIAM_BITS-1:0];
    return o;
  endfunction

  function automatic in_t pack_tetra(int v[12]);
    in_t t;
    for (int i = 0; i < 12; i++) t[191-16*i -: 16] = v[i][15:0];
    return t;
  endfunction

  function automatic in_t random_tetra();
    int v[12];
    int span, jit;
    case ($urandom_range(3))
      0: for (int i = 0; i < 12; i++) v[i] = $urandom;
      1: begin
        span = 1 << $urandom_range(13, 1);
        for (int i = 0; i < 12; i++)
          v[i] = (i < 3 ? $signed(16'($urandom)) / 2 : v[i%3]) +
                 $urandom_range(2*span) - span;
      end
      default: begin
        span = 1 << $urandom_range(14, 2);
        jit = $urandom_range(2);
        for (int i = 0; i < 9; i++) v[i] = $urandom_range(2*span) - span;
        for (int k = 0; k < 3; k++)
          v[9+k] = v[k] + v[3+k] - v[6+k] + $urandom_range(jit);
      end
    endcase
    return pack_tetra(v);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) shape_q.push_back(tetra_shape(in_data));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (tetra_q.size() == 0 ||
                     (n_issued == DRAIN_AT &&
                      (shape_q.size() != 0 || (in_valid && in_ready)))) begin
          in_valid <= 1'b0;
        end else if (n_issued < n_total - CALM_TAIL && $urandom_range(7) == 0) begin
          send_gap <= $urandom_range(4);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= tetra_q.pop_front();
          n_issued <= n_issued + 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_o;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (shape_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected transaction: %p", out_data);
        end else begin
          exp_o = shape_q.pop_front();
          n_checked++;
          if (exp_o.degenerate) n_degen++;
          else if (exp_o.diameter_out == {DIAM_BITS{1'b1}}) n_sat++;
          if (out_data !== exp_o) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch #%0d: vol %h/%h diam %h/%h degen %b/%b (exp/got)",
                       n_checked, exp_o.volume_out, out_data.volume_out,
                       exp_o.diameter_out, out_data.diameter_out,
                       exp_o.degenerate, out_data.degenerate);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else if (n_issued < n_total - CALM_TAIL && $urandom_range(7) == 0) begin
        recv_gap <= $urandom_range(4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    tetra_q.push_back(pack_tetra('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
    tetra_q.push_back(pack_tetra('{0,0,0, 256,0,0, 0,256,0, 0,0,256}));
    tetra_q.push_back(pack_tetra('{-32768,-32768,-32768, 32767,-32768,-32768,
                                   -32768,32767,-32768, -32768,-32768,32767}));
    tetra_q.push_back(pack_tetra('{32767,32767,32767, -32768,32767,32767,
                                   32767,-32768,32767, 32767,32767,-32768}));
    tetra_q.push_back(pack_tetra('{-1,-1,-1, 0,0,0, 1,2,3, 2,4,6}));
    tetra_q.push_back(pack_tetra('{0,0,0, 1,0,0, 0,1,0, 0,0,1}));
    tetra_q.push_back(pack_tetra('{0,0,0, 2,0,0, 0,3,0, 0,0,1}));
    tetra_q.push_back(pack_tetra('{0,0,0, 6,0,0, 0,1,0, 0,0,1}));
    tetra_q.push_back(pack_tetra('{-32768,-32768,0, 32767,32767,0,
                                   32767,-32768,0, 0,0,1}));
    tetra_q.push_back(pack_tetra('{-20000,0,0, 20000,0,0, 0,20000,0, 0,100,3}));
    tetra_q.push_back(pack_tetra('{256,256,256, 256,-256,-256,
                                   -256,256,-256, -256,-256,256}));
    tetra_q.push_back(pack_tetra('{-32768,0,0, 32767,0,0, 0,-32768,0, 0,0,32767}));
    tetra_q.push_back(pack_tetra('{100,200,300, 100,200,300, 5,6,7, -8,9,10}));
    tetra_q.push_back(pack_tetra('{-1,-1,-1, -1,-1,-1, -1,-1,-1, -1,-1,-1}));
    for (int i = 0; i < N_RANDOM; i++) tetra_q.push_back(random_tetra());
    n_total = tetra_q.size();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (tetra_q.size() != 0) @(posedge clk);
    @(posedge clk);
    while (in_valid || shape_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    $display("%0d tetrahedra checked: %0d flat or tiny, %0d with diameter clipped",
             n_checked, n_degen, n_sat);
    $display("%0d mismatched or unexpected transactions", n_bad);
    if (n_bad == 0 && shape_q.size() == 0)
      $display("tetrahedron_volume_circumdiameter regression: pass");
    else
      $display("tetrahedron_volume_circumdiameter regression: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("tetrahedron_volume_circumdiameter regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
